/* rtl/es2jd_pkg.sv */
// shared types and constants for the epoch seconds to julian date core
package es2jd_pkg;

    // input beat
    typedef struct packed {
        logic signed [63:0] epoch_seconds;
        logic        [59:0] frac_attoseconds;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic signed [39:0] cal_year;
        logic        [3:0]  cal_month;
        logic        [4:0]  cal_day;
        logic        [4:0]  cal_hour;
        logic        [5:0]  cal_minute;
        logic        [5:0]  cal_second;
        logic        [59:0] out_attoseconds;
    } t_out_item;

    // control and sideband that ride along the divider stages
    typedef struct packed {
        logic        valid;
        logic [59:0] atto;
    } t_div_tag;

    localparam int Q_BITS = 38;   // quotient bits of the cluster division
    localparam int W_BITS = 65;   // biased dividend width

    // cluster divider: dividend over 2^7 split into quotient digits
    localparam int DIG_BITS    = 12;
    localparam int DIGITS      = 5;
    localparam int NUM_BITS    = DIG_BITS * DIGITS;
    localparam int RECIP_SHIFT = 52;

    localparam logic [26:0] CLUSTER_SECS = 27'd126230400;  // 1461 days
    localparam logic [26:0] YEAR_SECS_1  = 27'd31536000;
    localparam logic [26:0] YEAR_SECS_2  = 27'd63072000;
    localparam logic [26:0] YEAR_SECS_3  = 27'd94608000;
    localparam logic [26:0] BASE_OFFSET  = 27'd94694400;   // 1970-01-01 to 1973-01-01

    // cluster length is 2^7 times this odd part
    localparam logic [19:0] CLUSTER_ODD   = 20'd986175;
    localparam logic [32:0] CLUSTER_RECIP = 33'd4566734736;  // 2^52 / 986175, rounded up

    // dividend bias: 2^37 clusters minus the base offset keeps it positive
    localparam logic [W_BITS-1:0] W_OFFSET =
        (W_BITS'(CLUSTER_SECS) << 37) - W_BITS'(BASE_OFFSET);

    // year bias: base year plus 2^39, which cancels the 2^37 cluster bias mod 2^40
    localparam logic [39:0] YEAR_BIAS = 40'd1973 + 40'h80_0000_0000;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // reciprocals for exact division after dropping the power-of-two factor
    localparam logic [18:0] DAY_RECIP  = 19'd397683;  // 2^28 / 675, rounded up
    localparam logic [12:0] HOUR_RECIP = 13'd4661;    // 2^20 / 225, rounded up
    localparam logic [10:0] MIN_RECIP  = 11'd1093;    // 2^14 / 15, rounded up

    // first day of each month, counted from the start of the year
    localparam logic [8:0] MONTH_START_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] MONTH_START_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

endpackage

/* rtl/es2jd_div.sv */
// pipelined divider by the four-year cluster length, two stages per 12-bit quotient digit
module es2jd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  es2jd_pkg::t_div_tag                i_tag,
    input  logic [es2jd_pkg::W_BITS-1:0]       i_dividend,
    output es2jd_pkg::t_div_tag                o_tag,
    output logic [es2jd_pkg::Q_BITS-1:0]       o_quot,
    output logic [26:0]                        o_rem
);

    // the low seven dividend bits ride along, the rest is divided by the odd part

    // multiply stage of each digit
    es2jd_pkg::t_div_tag                                   r_a_tag  [es2jd_pkg::DIGITS];
    logic [31:0]                                           r_a_part [es2jd_pkg::DIGITS];
    logic [es2jd_pkg::NUM_BITS-es2jd_pkg::DIG_BITS-1:0]    r_a_num  [es2jd_pkg::DIGITS];
    logic [6:0]                                            r_a_low  [es2jd_pkg::DIGITS];
    logic [es2jd_pkg::DIG_BITS-1:0]                        r_a_q    [es2jd_pkg::DIGITS];

    // subtract stage of each digit
    es2jd_pkg::t_div_tag                                   r_b_tag  [es2jd_pkg::DIGITS];
    logic [19:0]                                           r_b_rem  [es2jd_pkg::DIGITS];
    logic [es2jd_pkg::NUM_BITS-1:0]                        r_b_num  [es2jd_pkg::DIGITS];
    logic [6:0]                                            r_b_low  [es2jd_pkg::DIGITS];

    for (genvar d = 0; d < es2jd_pkg::DIGITS; d++) begin : g_digit
        es2jd_pkg::t_div_tag               tag_in;
        logic [19:0]                       rem_in;
        logic [es2jd_pkg::NUM_BITS-1:0]    num_in;
        logic [6:0]                        low_in;
        logic [31:0]                       part;
        logic [64:0]                       prod;
        logic [31:0]                       part_left;

        if (d == 0) begin : g_first
            assign tag_in = i_tag;
            assign rem_in = '0;
            assign num_in = es2jd_pkg::NUM_BITS'(i_dividend[es2jd_pkg::W_BITS-1:7]);
            assign low_in = i_dividend[6:0];
        end else begin : g_next
            assign tag_in = r_b_tag[d-1];
            assign rem_in = r_b_rem[d-1];
            assign num_in = r_b_num[d-1];
            assign low_in = r_b_low[d-1];
        end

        // remainder with the next digit appended stays below 2^32
        assign part = {rem_in, num_in[es2jd_pkg::NUM_BITS-1 -: es2jd_pkg::DIG_BITS]};
        assign prod = 65'(part) * 65'(es2jd_pkg::CLUSTER_RECIP);
        assign part_left = r_a_part[d] - 32'(r_a_q[d]) * 32'(es2jd_pkg::CLUSTER_ODD);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_tag[d].valid <= 1'b0;
                r_b_tag[d].valid <= 1'b0;
            end else begin
                r_a_tag[d].valid <= tag_in.valid;
                r_b_tag[d].valid <= r_a_tag[d].valid;
            end
            r_a_tag[d].atto <= tag_in.atto;
            r_a_part[d]     <= part;
            r_a_num[d]      <= num_in[es2jd_pkg::NUM_BITS-es2jd_pkg::DIG_BITS-1:0];
            r_a_low[d]      <= low_in;
            r_a_q[d]        <= es2jd_pkg::DIG_BITS'(prod >> es2jd_pkg::RECIP_SHIFT);
            r_b_tag[d].atto <= r_a_tag[d].atto;
            r_b_rem[d]      <= 20'(part_left);
            r_b_num[d]      <= {r_a_num[d], r_a_q[d]};
            r_b_low[d]      <= r_a_low[d];
        end
    end

    assign o_tag  = r_b_tag[es2jd_pkg::DIGITS-1];
    assign o_quot = es2jd_pkg::Q_BITS'(r_b_num[es2jd_pkg::DIGITS-1]);
    assign o_rem  = {r_b_rem[es2jd_pkg::DIGITS-1], r_b_low[es2jd_pkg::DIGITS-1]};

`ifndef SYNTHESIS
    // the remainder must have been fully reduced
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tag.valid |-> (r_b_rem[es2jd_pkg::DIGITS-1] < es2jd_pkg::CLUSTER_ODD))
        else $error("cluster remainder not reduced");

    // the biased cluster number fits the quotient port
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tag.valid |->
            (r_b_num[es2jd_pkg::DIGITS-1][es2jd_pkg::NUM_BITS-1:es2jd_pkg::Q_BITS] == '0))
        else $error("cluster quotient overflow");
`endif

endmodule

/* rtl/epoch_seconds_to_julian_date_core.sv */
// top level: signed epoch seconds to julian calendar date and time of day
//
// Converts a signed 64-bit count of seconds since 1970-01-01 00:00:00 into a
// julian calendar date (every fourth year a leap year) and time of day; the
// attosecond fraction is copied through untouched. The core is a fixed-latency
// pipeline with no back-pressure: busy is always low, so a beat can be issued
// with start in every cycle, and each result shows up on o_result with
// o_result_valid high for exactly one cycle, in issue order. The pipeline is
// one input register, then the cluster divider, which produces five 12-bit
// quotient digits with a multiply stage and a subtract stage each, and seven
// stages that split the remainder into year, day, month, hour, minute and
// second.
// The receiver cannot stall the core and must take every result as it comes.
module epoch_seconds_to_julian_date_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  es2jd_pkg::t_in_item    i_cmd,
    output logic                   o_result_valid,
    output es2jd_pkg::t_out_item   o_result
);

    // ---------------------------------------------------------------
    // input stage: bias the seconds so the floor division runs unsigned
    // (subtracts the 1973 base offset and adds 2^37 whole clusters)
    // ---------------------------------------------------------------
    es2jd_pkg::t_div_tag                r_in_tag;
    logic [es2jd_pkg::W_BITS-1:0]       r_w;
    logic [es2jd_pkg::W_BITS-1:0]       n_w;

    assign busy = 1'b0;
    assign n_w  = {i_cmd.epoch_seconds[63], i_cmd.epoch_seconds} + es2jd_pkg::W_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag.valid <= 1'b0;
        end else begin
            r_in_tag.valid <= start && !busy;
        end
        r_in_tag.atto <= i_cmd.frac_attoseconds;
        r_w           <= n_w;
    end

    // ---------------------------------------------------------------
    // cluster division: quotient is the biased cluster number,
    // remainder the seconds into the cluster starting at a 1973-like year
    // ---------------------------------------------------------------
    es2jd_pkg::t_div_tag                div_tag;
    logic [es2jd_pkg::Q_BITS-1:0]       div_quot;
    logic [26:0]                        div_rem;

    es2jd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_in_tag),
        .i_dividend (r_w),
        .o_tag      (div_tag),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ---------------------------------------------------------------
    // stage 1: year within the cluster, clamped to 3 so the last day of
    // the leap year stays in that year; full calendar year
    // ---------------------------------------------------------------
    logic        r1_valid;
    logic [59:0] r1_atto;
    logic [39:0] r1_year;
    logic        r1_leap;
    logic [24:0] r1_secs;
    logic [1:0]  n1_yidx;
    logic [26:0] n1_ybase;

    always_comb begin
        if (div_rem >= es2jd_pkg::YEAR_SECS_3) begin
            n1_yidx  = 2'd3;
            n1_ybase = es2jd_pkg::YEAR_SECS_3;
        end else if (div_rem >= es2jd_pkg::YEAR_SECS_2) begin
            n1_yidx  = 2'd2;
            n1_ybase = es2jd_pkg::YEAR_SECS_2;
        end else if (div_rem >= es2jd_pkg::YEAR_SECS_1) begin
            n1_yidx  = 2'd1;
            n1_ybase = es2jd_pkg::YEAR_SECS_1;
        end else begin
            n1_yidx  = 2'd0;
            n1_ybase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= div_tag.valid;
        end
        r1_atto <= div_tag.atto;
        // four years per cluster, wraps mod 2^40 like the output field
        r1_year <= {div_quot, 2'b00} + 40'(n1_yidx) + es2jd_pkg::YEAR_BIAS;
        r1_leap <= (n1_yidx == 2'd3);
        r1_secs <= 25'(div_rem - n1_ybase);
    end

    // ---------------------------------------------------------------
    // stage 2: day of year by reciprocal multiply (86400 = 2^7 * 675)
    // ---------------------------------------------------------------
    logic        r2_valid;
    logic [59:0] r2_atto;
    logic [39:0] r2_year;
    logic        r2_leap;
    logic [24:0] r2_secs;
    logic [36:0] r2_prod_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_atto   <= r1_atto;
        r2_year   <= r1_year;
        r2_leap   <= r1_leap;
        r2_secs   <= r1_secs;
        r2_prod_d <= 37'(r1_secs[24:7]) * 37'(es2jd_pkg::DAY_RECIP);
    end

    // ---------------------------------------------------------------
    // stage 3: day of year and second of day
    // ---------------------------------------------------------------
    logic        r3_valid;
    logic [59:0] r3_atto;
    logic [39:0] r3_year;
    logic        r3_leap;
    logic [8:0]  r3_days;
    logic [16:0] r3_sod;
    logic [8:0]  n3_days;
    logic [24:0] n3_day_base;

    assign n3_days     = r2_prod_d[36:28];
    assign n3_day_base = 25'(n3_days) * 25'(es2jd_pkg::SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_atto <= r2_atto;
        r3_year <= r2_year;
        r3_leap <= r2_leap;
        r3_days <= n3_days;
        r3_sod  <= 17'(r2_secs - n3_day_base);
    end

    // ---------------------------------------------------------------
    // stage 4: month index from the month start table; hour multiply
    // (3600 = 2^4 * 225)
    // ---------------------------------------------------------------
    logic        r4_valid;
    logic [59:0] r4_atto;
    logic [39:0] r4_year;
    logic        r4_leap;
    logic [8:0]  r4_days;
    logic [3:0]  r4_midx;
    logic [16:0] r4_sod;
    logic [24:0] r4_prod_h;
    logic [3:0]  n4_midx;

    always_comb begin
        n4_midx = '0;
        // month starts are increasing, so the count of passed starts is the month
        for (int k = 1; k < 12; k++) begin
            if (r3_days >= (r3_leap ? es2jd_pkg::MONTH_START_LEAP[k]
                                    : es2jd_pkg::MONTH_START_COMMON[k])) begin
                n4_midx = n4_midx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_atto   <= r3_atto;
        r4_year   <= r3_year;
        r4_leap   <= r3_leap;
        r4_days   <= r3_days;
        r4_midx   <= n4_midx;
        r4_sod    <= r3_sod;
        r4_prod_h <= 25'(r3_sod[16:4]) * 25'(es2jd_pkg::HOUR_RECIP);
    end

    // ---------------------------------------------------------------
    // stage 5: day of month, hour and second of hour
    // ---------------------------------------------------------------
    logic        r5_valid;
    logic [59:0] r5_atto;
    logic [39:0] r5_year;
    logic [3:0]  r5_month;
    logic [4:0]  r5_day;
    logic [4:0]  r5_hour;
    logic [11:0] r5_soh;
    logic [8:0]  n5_mstart;
    logic [4:0]  n5_hour;
    logic [16:0] n5_hour_base;

    assign n5_mstart    = r4_leap ? es2jd_pkg::MONTH_START_LEAP[r4_midx]
                                  : es2jd_pkg::MONTH_START_COMMON[r4_midx];
    assign n5_hour      = r4_prod_h[24:20];
    assign n5_hour_base = 17'(n5_hour) * 17'(es2jd_pkg::SECS_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_atto  <= r4_atto;
        r5_year  <= r4_year;
        r5_month <= r4_midx + 4'd1;
        r5_day   <= 5'(r4_days - n5_mstart + 9'd1);
        r5_hour  <= n5_hour;
        r5_soh   <= 12'(r4_sod - n5_hour_base);
    end

    // ---------------------------------------------------------------
    // stage 6: minute multiply (60 = 2^2 * 15)
    // ---------------------------------------------------------------
    logic        r6_valid;
    logic [59:0] r6_atto;
    logic [39:0] r6_year;
    logic [3:0]  r6_month;
    logic [4:0]  r6_day;
    logic [4:0]  r6_hour;
    logic [11:0] r6_soh;
    logic [19:0] r6_prod_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_atto   <= r5_atto;
        r6_year   <= r5_year;
        r6_month  <= r5_month;
        r6_day    <= r5_day;
        r6_hour   <= r5_hour;
        r6_soh    <= r5_soh;
        r6_prod_m <= 20'(r5_soh[11:2]) * 20'(es2jd_pkg::MIN_RECIP);
    end

    // ---------------------------------------------------------------
    // stage 7: minute and second, output register
    // ---------------------------------------------------------------
    logic        r7_valid;
    logic [59:0] r7_atto;
    logic [39:0] r7_year;
    logic [3:0]  r7_month;
    logic [4:0]  r7_day;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_minute;
    logic [5:0]  r7_second;
    logic [5:0]  n7_minute;
    logic [11:0] n7_min_base;

    assign n7_minute   = r6_prod_m[19:14];
    assign n7_min_base = 12'(n7_minute) * es2jd_pkg::SECS_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
        r7_atto   <= r6_atto;
        r7_year   <= r6_year;
        r7_month  <= r6_month;
        r7_day    <= r6_day;
        r7_hour   <= r6_hour;
        r7_minute <= n7_minute;
        r7_second <= 6'(r6_soh - n7_min_base);
    end

    // one-cycle result beat
    assign o_result_valid           = r7_valid;
    assign o_result.cal_year        = r7_year;
    assign o_result.cal_month       = r7_month;
    assign o_result.cal_day         = r7_day;
    assign o_result.cal_hour        = r7_hour;
    assign o_result.cal_minute      = r7_minute;
    assign o_result.cal_second      = r7_second;
    assign o_result.out_attoseconds = r7_atto;

`ifndef SYNTHESIS
    // month walk must land inside the year
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.cal_month >= 4'd1 && o_result.cal_month <= 4'd12))
        else $error("month out of range");

    // day subtraction against the month start table
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.cal_day >= 5'd1 && o_result.cal_day <= 5'd31))
        else $error("day out of range");

    // reciprocal for the hour split
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.cal_hour <= 5'd23))
        else $error("hour out of range");

    // reciprocal for the minute split and the final subtract
    a_min_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.cal_minute <= 6'd59 && o_result.cal_second <= 6'd59))
        else $error("minute or second out of range");
`endif

endmodule
